// ===== src/efw_pkg.sv =====
// shared types, constants and the control store of the dispatcher
`default_nettype none

package efw_pkg;

    // field widths
    localparam int DUR_W   = 32;
    localparam int WC_W    = 5;
    localparam int WORKER_W = 4;

    // parameter defaults and register reset
    localparam int MAX_WORKERS_DEF = 16;
    localparam logic [WC_W-1:0] WORKER_COUNT_RESET = 5'd16;

    // sequencer steps
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SCAN   = 3'd1;
    localparam logic [STEP_W-1:0] STEP_DRAIN  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_UPDATE = 3'd3;
    localparam logic [STEP_W-1:0] STEP_FILL   = 3'd4;

    // jump conditions
    localparam logic [1:0] JC_NEXT     = 2'd0;
    localparam logic [1:0] JC_LOOP     = 2'd1;
    localparam logic [1:0] JC_STALL    = 2'd2;
    localparam logic [1:0] JC_DISPATCH = 2'd3;

    // datapath control, one set per step
    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic fill;
        logic update;
    } efw_ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic fill_needed;
        logic idx_last;
        logic out_busy;
    } efw_stat_t;

    // one control word
    typedef struct packed {
        efw_ctrl_t         ctrl;
        logic [1:0]        jc;
        logic [STEP_W-1:0] target;
    } ucode_word_t;

    // control store
    function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_word_t w;
        w = '{ctrl: '{in_ready: 1'b0, rd_en: 1'b0, fill: 1'b0, update: 1'b0},
              jc: JC_NEXT, target: STEP_WAIT};
        unique case (step)
            STEP_WAIT: begin
                w.ctrl.in_ready = 1'b1;
                w.jc            = JC_DISPATCH;
                w.target        = STEP_FILL;
            end
            STEP_SCAN: begin
                w.ctrl.rd_en = 1'b1;
                w.jc         = JC_LOOP;
                w.target     = STEP_SCAN;
            end
            STEP_DRAIN: begin
                w.jc = JC_NEXT;
            end
            STEP_UPDATE: begin
                w.ctrl.update = 1'b1;
                w.jc          = JC_STALL;
                w.target      = STEP_WAIT;
            end
            STEP_FILL: begin
                w.ctrl.fill = 1'b1;
                w.jc        = JC_STALL;
                w.target    = STEP_WAIT;
            end
            default: begin
                w.jc     = JC_STALL;
                w.target = STEP_WAIT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== src/efw_channels_if.sv =====
// job and result stream interfaces
`default_nettype none

interface efw_job_if;
    import efw_pkg::*;
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] job_duration;
    modport source (output valid, output job_duration, input ready);
    modport sink   (input valid, input job_duration, output ready);
endinterface

interface efw_result_if;
    import efw_pkg::*;
    logic                valid;
    logic                ready;
    logic [WORKER_W-1:0] assigned_worker;
    modport source (output valid, output assigned_worker, input ready);
    modport sink   (input valid, input assigned_worker, output ready);
endinterface

`default_nettype wire

// ===== src/earliest_free_worker_dispatcher.sv =====
// Earliest-free-worker dispatcher, top level.
// A job for a still unused worker is dispatched straight from intake; any other job first
// scans N remaining-time RAM entries, N the larger of the clamped worker_count and the
// count of the previous dispatch, one remaining-time RAM entry scanned per cycle.
// A new job is taken only once the previous one is dispatched; a held result stalls dispatch.
// Reset clears sequencer, fill count, pending subtraction and result valid; worker_count is 16.
`default_nettype none

module earliest_free_worker_dispatcher #(
    parameter int MAX_WORKERS = efw_pkg::MAX_WORKERS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [efw_pkg::WC_W-1:0]  cfg_wdata,
    efw_job_if.sink                        job,
    efw_result_if.source                   result
);
    import efw_pkg::*;

    logic [WC_W-1:0] worker_count_reg;
    efw_ctrl_t       ctrl;
    efw_stat_t       stat;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            worker_count_reg <= WORKER_COUNT_RESET;
        else if (cfg_we)
            worker_count_reg <= cfg_wdata;
    end

    efw_ucode u_ucode (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    efw_datapath #(
        .MAX_WORKERS (MAX_WORKERS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .worker_count    (worker_count_reg),
        .ctrl            (ctrl),
        .in_valid        (job.valid),
        .job_duration    (job.job_duration),
        .out_ready       (result.ready),
        .stat            (stat),
        .out_valid       (result.valid),
        .assigned_worker (result.assigned_worker)
    );

    assign job.ready = ctrl.in_ready;

`ifndef SYNTHESIS
    // a dispatch step that fires always presents a result
    a_dispatch_result: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.fill || ctrl.update) && !stat.out_busy |=> result.valid)
        else $error("dispatch did not produce a result");

    // intake closes right after a job transfer
    a_intake_closes: assert property (@(posedge clk) disable iff (!rst_n)
        job.valid && job.ready |=> !job.ready)
        else $error("job intake stayed open after a transfer");

    // a new result only comes from a dispatch step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(ctrl.fill || ctrl.update))
        else $error("result appeared without a dispatch");

    // no ram scan while taking a job
    a_scan_not_intake: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.rd_en |-> !job.ready && !ctrl.fill && !ctrl.update)
        else $error("scan overlaps intake or dispatch");
`endif

endmodule

`default_nettype wire

// ===== src/efw_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module efw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic                                  re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/efw_ucode.sv =====
// step counter and control store sequencer
`default_nettype none

module efw_ucode (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire efw_pkg::efw_stat_t stat,
    output efw_pkg::efw_ctrl_t      ctrl
);
    import efw_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    ucode_word_t       word;

    assign word = ucode_rom(step_reg);
    assign ctrl = word.ctrl;

    // next step from the jump condition
    always_comb
    begin
        unique case (word.jc)
            JC_NEXT:     step_next = step_reg + 1'b1;
            JC_LOOP:     step_next = stat.idx_last ? step_reg + 1'b1 : word.target;
            JC_STALL:    step_next = stat.out_busy ? step_reg : word.target;
            JC_DISPATCH:
            begin
                if (!stat.in_valid)
                    step_next = step_reg;
                else if (stat.fill_needed)
                    step_next = word.target;
                else
                    step_next = step_reg + 1'b1;
            end
            default:     step_next = STEP_WAIT;
        endcase
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_WAIT;
        else
            step_reg <= step_next;
    end

endmodule

`default_nettype wire

// ===== src/efw_datapath.sv =====
// remaining-time store, minimum scan and result register
`default_nettype none

module efw_datapath #(
    parameter int MAX_WORKERS = efw_pkg::MAX_WORKERS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [efw_pkg::WC_W-1:0]      worker_count,
    input  wire efw_pkg::efw_ctrl_t            ctrl,
    input  wire logic                          in_valid,
    input  wire logic [efw_pkg::DUR_W-1:0]     job_duration,
    input  wire logic                          out_ready,
    output efw_pkg::efw_stat_t                 stat,
    output logic                               out_valid,
    output logic [efw_pkg::WORKER_W-1:0]       assigned_worker
);
    import efw_pkg::*;

    localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CNT_W = $clog2(MAX_WORKERS + 1);

    // a dispatch leaves its subtraction pending; the next scan applies it
    // to each entry but the one just dispatched to as it is read, and writes each entry back
    logic [DUR_W-1:0]    dur_reg, dur_next;
    logic [DUR_W-1:0]    sub_reg, sub_next;
    logic [CNT_W-1:0]    sub_n_reg, sub_n_next;
    logic [IDX_W-1:0]    sub_pick_reg, sub_pick_next;
    logic [DUR_W-1:0]    min_reg, min_next;
    logic [IDX_W-1:0]    pick_reg, pick_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic [CNT_W-1:0]    filled_reg, filled_next;
    logic                out_vld_reg, out_vld_next;
    logic [WORKER_W-1:0] out_data_reg, out_data_next;

    logic [CNT_W-1:0]    active_n;
    logic [CNT_W-1:0]    scan_n;
    logic                accept;
    logic                go;
    logic [DUR_W-1:0]    rd_data;
    logic                sub_hit;
    logic                cmp_in_use;
    logic [DUR_W-1:0]    cand;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [DUR_W-1:0]    wdata;
    logic [IDX_W+WORKER_W-1:0] pick_ext;
    logic [IDX_W+WORKER_W-1:0] fill_ext;

    // clamp the worker count into 1..MAX_WORKERS
    always_comb
    begin
        if (worker_count == '0)
            active_n = CNT_W'(1);
        else if (int'(worker_count) > MAX_WORKERS)
            active_n = CNT_W'(MAX_WORKERS);
        else
            active_n = CNT_W'(worker_count);
    end

    // scan covers the workers in use and those with a pending subtraction
    assign scan_n = (sub_n_reg > active_n) ? sub_n_reg : active_n;

    assign accept = in_valid && ctrl.in_ready;
    assign go     = !(out_vld_reg && !out_ready);

    assign stat.in_valid    = in_valid;
    assign stat.fill_needed = filled_reg < active_n;
    assign stat.idx_last    = CNT_W'(idx_reg) == (scan_n - 1'b1);
    assign stat.out_busy    = !go;

    assign sub_hit    = (CNT_W'(cmp_idx_reg) < sub_n_reg) && (cmp_idx_reg != sub_pick_reg);
    assign cmp_in_use = CNT_W'(cmp_idx_reg) < active_n;
    assign cand       = sub_hit ? rd_data - sub_reg : rd_data;
    assign pick_ext   = {{WORKER_W{1'b0}}, pick_reg};
    assign fill_ext   = {{WORKER_W{1'b0}}, filled_reg[IDX_W-1:0]};

    efw_ram #(
        .WIDTH (DUR_W),
        .DEPTH (MAX_WORKERS)
    ) u_time_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ctrl.rd_en),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // datapath next state
    always_comb
    begin
        dur_next      = dur_reg;
        sub_next      = sub_reg;
        sub_n_next    = sub_n_reg;
        sub_pick_next = sub_pick_reg;
        min_next      = min_reg;
        pick_next     = pick_reg;
        idx_next      = idx_reg;
        filled_next   = filled_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        out_data_next = out_data_reg;
        we            = 1'b0;
        waddr         = pick_reg;
        wdata         = dur_reg;

        // job intake
        if (accept)
        begin
            dur_next = job_duration;
            idx_next = '0;
        end
        else if (ctrl.rd_en)
        begin
            idx_next = idx_reg + 1'b1;
        end

        // write back each scanned entry with the pending subtraction applied
        if (cmp_vld_reg)
        begin
            we    = 1'b1;
            waddr = cmp_idx_reg;
            wdata = cand;
        end

        // running minimum over the workers in use, lowest index wins ties
        if (cmp_vld_reg && cmp_in_use && (cmp_idx_reg == '0 || cand < min_reg))
        begin
            min_next  = cand;
            pick_next = cmp_idx_reg;
        end

        // first job of an unused worker
        if (ctrl.fill && go)
        begin
            we            = 1'b1;
            waddr         = filled_reg[IDX_W-1:0];
            wdata         = dur_reg;
            filled_next   = filled_reg + 1'b1;
            out_vld_next  = 1'b1;
            out_data_next = fill_ext[WORKER_W-1:0];
        end

        // dispatch to the earliest free worker, subtraction left pending
        if (ctrl.update && go)
        begin
            sub_next      = min_reg;
            sub_n_next    = active_n;
            sub_pick_next = pick_reg;
            we            = 1'b1;
            waddr         = pick_reg;
            wdata         = dur_reg;
            out_vld_next  = 1'b1;
            out_data_next = pick_ext[WORKER_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg  <= '0;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
            sub_n_reg   <= '0;
        end
        else
        begin
            filled_reg  <= filled_next;
            out_vld_reg <= out_vld_next;
            cmp_vld_reg <= ctrl.rd_en;
            sub_n_reg   <= sub_n_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dur_reg      <= dur_next;
        sub_reg      <= sub_next;
        sub_pick_reg <= sub_pick_next;
        min_reg      <= min_next;
        pick_reg     <= pick_next;
        idx_reg      <= idx_next;
        cmp_idx_reg  <= idx_reg;
        out_data_reg <= out_data_next;
    end

    assign out_valid       = out_vld_reg;
    assign assigned_worker = out_data_reg;

endmodule

`default_nettype wire
